/* src/tlqe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqe_pkg
// Shared types, constants and helpers for the thick line quad expander.
// ----------------------------------------------------------------------------
package tlqe_pkg;

  localparam int BUFFER_WORDS_DEF = 65536;
  localparam int WORDS_PER_VERTEX = 3;
  localparam int QUAD_VERTICES    = 6;
  localparam int ROOT_STEPS       = 32;  // two radicand bits consumed per step
  localparam int DIV_STEPS        = 24;  // quotient bits per offset
  localparam int MOD_STEPS        = 17;  // start index reduction steps
  localparam int NORM_STEPS       = 5;   // binary normalize: 16, 8, 4, 2, 1

  // Segment after front-end classification.
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        ux;         // normalized |dx|
    logic [30:0]        uy;         // normalized |dy|
    logic [23:0]        thickness;
    logic [7:0]         line_type;
    logic [15:0]        buffer_start;
    logic               neg_x;      // x offset is negative
    logic               neg_y;      // y offset is negative
    logic               zero_len;   // A == B
  } seg_item_t;

  // Clamp a 34-bit signed sum to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* src/tlqe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqe_front
// Segment intake: direction, magnitudes, signs and normalization shift.
// ----------------------------------------------------------------------------
module tlqe_front import tlqe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               seg_valid,
  output logic               seg_stall,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic [23:0]        thickness,
  input  logic [7:0]         line_type,
  input  logic [15:0]        buffer_start,
  output logic               fq_valid,
  output seg_item_t          fq_item,
  input  logic               fq_full
);

  logic               h_full;
  logic signed [31:0] h_ax, h_ay, h_bx, h_by;
  logic [23:0]        h_thick;
  logic [7:0]         h_type;
  logic [15:0]        h_start;

  logic        n_busy;
  logic [2:0]  n_step;
  logic [30:0] m;

  logic               take;
  logic               accept;
  logic signed [32:0] dx, dy;
  logic [32:0]        ux33, uy33, m33;
  logic               big;
  logic [4:0]         shamt;
  logic               do_shift;

  assign seg_stall = h_full;
  assign accept    = seg_valid && !h_full;
  assign take      = h_full && !n_busy;

  always_comb begin
    dx   = {h_bx[31], h_bx} - {h_ax[31], h_ax};
    dy   = {h_by[31], h_by} - {h_ay[31], h_ay};
    ux33 = dx[32] ? 33'(-dx) : 33'(dx);
    uy33 = dy[32] ? 33'(-dy) : 33'(dy);
    m33  = (ux33 > uy33) ? ux33 : uy33;
    big  = (m33[32:31] != 2'b00);
    shamt    = 5'd16 >> (n_step - 3'd1);
    do_shift = ((m >> (5'd31 - shamt)) == 31'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_full   <= 1'b0;
      n_busy   <= 1'b0;
      fq_valid <= 1'b0;
      n_step   <= 3'd0;
    end else begin
      if (take) begin
        h_full <= 1'b0;
      end else if (accept) begin
        h_full <= 1'b1;
      end

      if (take) begin
        n_busy <= 1'b1;
        n_step <= 3'd1;
      end else if (n_busy && !fq_valid) begin
        if (n_step == 3'(NORM_STEPS)) begin
          fq_valid <= 1'b1;
        end else begin
          n_step <= n_step + 3'd1;
        end
      end else if (fq_valid && !fq_full) begin
        fq_valid <= 1'b0;
        n_busy   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_ax    <= ax;
      h_ay    <= ay;
      h_bx    <= bx;
      h_by    <= by;
      h_thick <= thickness;
      h_type  <= line_type;
      h_start <= buffer_start;
    end
    if (take) begin
      fq_item.ax           <= h_ax;
      fq_item.ay           <= h_ay;
      fq_item.bx           <= h_bx;
      fq_item.by           <= h_by;
      fq_item.thickness    <= h_thick;
      fq_item.line_type    <= h_type;
      fq_item.buffer_start <= h_start;
      fq_item.neg_x        <= !dy[32] && (dy != 33'sd0);
      fq_item.neg_y        <= dx[32];
      fq_item.zero_len     <= (dx == 33'sd0) && (dy == 33'sd0);
      if (big) begin
        fq_item.ux <= ux33[31:1];
        fq_item.uy <= uy33[31:1];
        m          <= m33[31:1];
      end else begin
        fq_item.ux <= ux33[30:0];
        fq_item.uy <= uy33[30:0];
        m          <= m33[30:0];
      end
    end else if (n_busy && !fq_valid && do_shift) begin
      fq_item.ux <= fq_item.ux << shamt;
      fq_item.uy <= fq_item.uy << shamt;
      m          <= m << shamt;
    end
  end

endmodule

/* src/tlqe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqe_queue
// Two-entry segment queue between front end and back end.
// ----------------------------------------------------------------------------
module tlqe_queue import tlqe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  seg_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output seg_item_t q_item
);

  seg_item_t   mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

/* src/tlqe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqe_back
// Offset arithmetic (square root, two divisions) and six-vertex emission.
// ----------------------------------------------------------------------------
module tlqe_back import tlqe_pkg::*; #(
  parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  seg_item_t          q_item,
  output logic               q_pop,
  output logic               vert_valid,
  input  logic               vert_stall,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic [7:0]         vertex_type,
  output logic [15:0]        word_index,
  output logic [2:0]         vertex_number,
  output logic               last_vertex
);

  localparam int IW = $clog2(BUFFER_WORDS) + 2;
  localparam int MW = IW + 16;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQR  = 8'b0000_0010,
    S_SUM  = 8'b0000_0100,
    S_ROOT = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_LDIV = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t    state;
  seg_item_t it;
  logic [4:0] cnt;
  logic [2:0] vk;

  logic [61:0] sqx, sqy;
  logic [62:0] s;
  logic [63:0] res, bitv;
  logic [54:0] prodx, prody;
  logic [32:0] dvs;
  logic [32:0] remx, remy;
  logic [23:0] nsx, nsy;
  logic [23:0] qx, qy;
  logic [MW-1:0] idx, md;

  logic [63:0] trial;
  logic [55:0] numx, numy;
  logic [33:0] tx, ty;
  logic        out_free;
  logic [MW-1:0] idx_inc;
  logic signed [24:0] ox, oy;
  logic        use_a, plus;
  logic signed [33:0] sx, sy;
  logic signed [31:0] base_x, base_y;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !vert_valid || !vert_stall;

  always_comb begin
    trial   = res + bitv;
    numx    = 56'(prodx) + 56'(res[31:0]);
    numy    = 56'(prody) + 56'(res[31:0]);
    tx      = {remx, nsx[23]};
    ty      = {remy, nsy[23]};
    idx_inc = idx + MW'(WORDS_PER_VERTEX);
    if (idx_inc >= MW'(BUFFER_WORDS)) begin
      idx_inc = idx_inc - MW'(BUFFER_WORDS);
    end
    ox = it.zero_len ? 25'sd0 : (it.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
    oy = it.zero_len ? 25'sd0 : (it.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
    // A+o, A-o, B+o, B+o, B-o, A-o
    use_a  = (vk == 3'd0) || (vk == 3'd1) || (vk == 3'd5);
    plus   = (vk == 3'd0) || (vk == 3'd2) || (vk == 3'd3);
    base_x = use_a ? it.ax : it.bx;
    base_y = use_a ? it.ay : it.by;
    sx = plus ? (34'(base_x) + 34'(ox)) : (34'(base_x) - 34'(ox));
    sy = plus ? (34'(base_y) + 34'(oy)) : (34'(base_y) - 34'(oy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= 5'd0;
      vk         <= 3'd0;
      vert_valid <= 1'b0;
    end else begin
      // output slot loads a vertex whenever it is free and one is ready
      if (out_free) begin
        vert_valid <= (state == S_EMIT);
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_SQR;
          end
        end
        S_SQR: state <= S_SUM;
        S_SUM: begin
          cnt   <= 5'd0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(ROOT_STEPS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_LDIV;
        S_LDIV: begin
          cnt   <= 5'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_STEPS - 1)) begin
            vk    <= 3'd0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            vk <= vk + 3'd1;
            if (vk == 3'(QUAD_VERTICES - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          it <= q_item;
        end
      end
      S_SQR: begin
        sqx <= 62'(it.ux) * 62'(it.ux);
        sqy <= 62'(it.uy) * 62'(it.uy);
      end
      S_SUM: begin
        s    <= 63'(sqx) + 63'(sqy);
        res  <= 64'd0;
        bitv <= 64'd1 << 62;
        idx  <= MW'(it.buffer_start);
        md   <= MW'(BUFFER_WORDS) << 16;
      end
      S_ROOT: begin
        if ({1'b0, s} >= trial) begin
          s   <= 63'({1'b0, s} - trial);
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        // start mod BUFFER_WORDS by restoring subtraction
        if ((cnt < 5'(MOD_STEPS)) && (idx >= md)) begin
          idx <= idx - md;
        end
        md <= md >> 1;
      end
      S_MUL: begin
        prodx <= 55'(it.uy) * 55'(it.thickness);
        prody <= 55'(it.ux) * 55'(it.thickness);
      end
      S_LDIV: begin
        dvs  <= {res[31:0], 1'b0};
        remx <= 33'(numx[55:24]);
        remy <= 33'(numy[55:24]);
        nsx  <= numx[23:0];
        nsy  <= numy[23:0];
      end
      S_DIV: begin
        if (tx >= 34'(dvs)) begin
          remx <= 33'(tx - 34'(dvs));
          qx   <= {qx[22:0], 1'b1};
        end else begin
          remx <= tx[32:0];
          qx   <= {qx[22:0], 1'b0};
        end
        if (ty >= 34'(dvs)) begin
          remy <= 33'(ty - 34'(dvs));
          qy   <= {qy[22:0], 1'b1};
        end else begin
          remy <= ty[32:0];
          qy   <= {qy[22:0], 1'b0};
        end
        nsx <= nsx << 1;
        nsy <= nsy << 1;
      end
      S_EMIT: begin
        if (out_free) begin
          vertex_x      <= sat32(sx);
          vertex_y      <= sat32(sy);
          vertex_type   <= it.line_type;
          word_index    <= idx[15:0];
          vertex_number <= vk;
          last_vertex   <= (vk == 3'(QUAD_VERTICES - 1));
          idx           <= idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/thick_line_quad_expander.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_line_quad_expander
// Expands a segment into a six-vertex thick-line quad (two triangles).
// ----------------------------------------------------------------------------
// Per segment the back end runs square-root steps, shared division steps and
// vertex emits, with setup states between, and takes the next segment only when idle.
// The front end runs ahead through a two-entry queue.
// Reset: synchronous, clears all handshake and sequencing state; no data state.
// ----------------------------------------------------------------------------
module thick_line_quad_expander import tlqe_pkg::*; #(
  parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // segment channel
  input  logic               seg_valid,
  output logic               seg_stall,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic [23:0]        thickness,
  input  logic [7:0]         line_type,
  input  logic [15:0]        buffer_start,
  // vertex channel
  output logic               vert_valid,
  input  logic               vert_stall,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic [7:0]         vertex_type,
  output logic [15:0]        word_index,
  output logic [2:0]         vertex_number,
  output logic               last_vertex
);

  // Front end: holds one segment, forms B-A, the signs of the offset and
  // scales |dx|,|dy| by a common power of two so the larger is in [2^30, 2^31).
  logic      fq_valid;
  logic      fq_full;
  seg_item_t fq_item;

  // Queue output toward the back end.
  logic      q_valid;
  logic      q_pop;
  seg_item_t q_item;

  tlqe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .seg_valid    (seg_valid),
    .seg_stall    (seg_stall),
    .ax           (ax),
    .ay           (ay),
    .bx           (bx),
    .by           (by),
    .thickness    (thickness),
    .line_type    (line_type),
    .buffer_start (buffer_start),
    .fq_valid     (fq_valid),
    .fq_item      (fq_item),
    .fq_full      (fq_full)
  );

  // A transfer into the queue happens when the front end is done and it has room.
  tlqe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_valid),
    .push_item (fq_item),
    .full      (fq_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Back end: squares, bit-pair square root, rounded division of both offset
  // magnitudes in parallel, then one vertex per cycle, unless stalled, into a
  // registered output slot, so the next segment starts while the last vertex waits.
  tlqe_back #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .vert_valid    (vert_valid),
    .vert_stall    (vert_stall),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .vertex_type   (vertex_type),
    .word_index    (word_index),
    .vertex_number (vertex_number),
    .last_vertex   (last_vertex)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Segment-to-quad expander check: directed table of corner segments, then
// random segments under random gaps and stalls, each vertex against a model.
// ----------------------------------------------------------------------------
module tb_top;
  import tlqe_pkg::*;

  localparam int NUM_RANDOM = 190;
  localparam longint CYCLE_LIMIT = 400000;

  // One segment as driven onto the input ports.
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [23:0]        thickness;
    logic [7:0]         line_type;
    logic [15:0]        buffer_start;
  } segment_t;

  // One vertex as seen on the output ports.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [7:0]         vtype;
    logic [15:0]        widx;
    logic [2:0]         vnum;
    logic               last;
  } vertex_t;

  // Directed row: a segment plus, where obvious, the offset it must produce.
  typedef struct {
    segment_t seg;
    bit       has_off;
    longint   ox;
    longint   oy;
  } seg_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_stall;
  logic signed [31:0] ax = '0, ay = '0, bx = '0, by = '0;
  logic [23:0] thickness = '0;
  logic [7:0]  line_type = '0;
  logic [15:0] buffer_start = '0;
  logic vert_valid;
  logic vert_stall = 1'b1;
  logic signed [31:0] vertex_x, vertex_y;
  logic [7:0]  vertex_type;
  logic [15:0] word_index;
  logic [2:0]  vertex_number;
  logic        last_vertex;

  always #1 clk = ~clk;

  thick_line_quad_expander DUT (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_stall(seg_stall),
    .ax(ax), .ay(ay), .bx(bx), .by(by),
    .thickness(thickness), .line_type(line_type), .buffer_start(buffer_start),
    .vert_valid(vert_valid), .vert_stall(vert_stall),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_type(vertex_type),
    .word_index(word_index), .vertex_number(vertex_number),
    .last_vertex(last_vertex)
  );

  vertex_t pending_vertices[$];
  int      error_count = 0;
  int      vertices_seen = 0;
  int      segments_sent = 0;
  longint  cycle_count = 0;
  bit      stim_done = 1'b0;
  bit      hold_off = 1'b0;   // receiver parked for the back-pressure test

  // Bit-serial integer square root, floor.
  function automatic longint unsigned floor_sqrt(input longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Offset vector: rotated direction, normalized and scaled to half width.
  task automatic quad_offset(input segment_t s, output longint ox, output longint oy);
    longint dx, dy;
    longint unsigned ux, uy, m, r, mx, my;
    dx = longint'(s.bx) - longint'(s.ax);
    dy = longint'(s.by) - longint'(s.ay);
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    ox = 0;
    oy = 0;
    if (ux != 0 || uy != 0) begin
      m = ux > uy ? ux : uy;
      if (m >= (64'd1 << 31)) begin
        ux >>= 1;
        uy >>= 1;
      end else begin
        while (m < (64'd1 << 30)) begin
          m <<= 1; ux <<= 1; uy <<= 1;
        end
      end
      r  = floor_sqrt(ux * ux + uy * uy);
      mx = (uy * s.thickness + r) / (2 * r);
      my = (ux * s.thickness + r) / (2 * r);
      ox = dy > 0 ? -longint'(mx) : longint'(mx);
      oy = dx < 0 ? -longint'(my) : longint'(my);
    end
  endtask

  // Queue the six vertices of one segment: A+o, A-o, B+o, B+o, B-o, A-o.
  task automatic expect_quad(input segment_t s, input bit has_off,
                             input longint fox, input longint foy);
    longint ox, oy, px, py, sx, sy;
    vertex_t v;
    quad_offset(s, ox, oy);
    if (has_off && (ox != fox || oy != foy)) begin
      $display("%0t: offset table mismatch expected (%0d,%0d) got (%0d,%0d)",
               $time, fox, foy, ox, oy);
      error_count++;
    end
    for (int k = 0; k < QUAD_VERTICES; k++) begin
      sx = (k == 0 || k == 2 || k == 3) ? 1 : -1;
      sy = sx;
      px = (k < 2 || k == 5) ? longint'(s.ax) : longint'(s.bx);
      py = (k < 2 || k == 5) ? longint'(s.ay) : longint'(s.by);
      v.x     = 32'(clamp32(px + sx * ox));
      v.y     = 32'(clamp32(py + sy * oy));
      v.vtype = s.line_type;
      v.widx  = 16'(s.buffer_start + WORDS_PER_VERTEX * k);
      v.vnum  = 3'(k);
      v.last  = (k == QUAD_VERTICES - 1);
      pending_vertices.push_back(v);
    end
  endtask

  // Hand one segment over at the falling edge and hold it until transferred.
  task automatic send_segment(input segment_t s, input bit has_off,
                              input longint fox, input longint foy);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    thickness = s.thickness; line_type = s.line_type;
    buffer_start = s.buffer_start;
    seg_valid = 1'b1;
    do @(posedge clk); while (seg_stall);
    expect_quad(s, has_off, fox, foy);
    segments_sent++;
    @(negedge clk);
    seg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    s.ax = rand_coord();
    s.ay = rand_coord();
    case ($urandom_range(0, 7))
      0: begin s.bx = s.ax; s.by = s.ay; end                // zero length
      1: begin s.bx = s.ax; s.by = rand_coord(); end        // vertical
      2: begin s.bx = s.ax + $urandom_range(0, 8) - 4;       // tiny delta
               s.by = s.ay + $urandom_range(0, 8) - 4; end
      default: begin s.bx = rand_coord(); s.by = rand_coord(); end
    endcase
    s.thickness    = ($urandom_range(0, 4) == 0) ? 24'hFFFFFF : 24'($urandom);
    s.line_type    = 8'($urandom);
    s.buffer_start = ($urandom_range(0, 4) == 0) ? 16'(16'hFFFF - $urandom_range(0, 20))
                                                 : 16'($urandom);
    return s;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst || hold_off) begin
      vert_stall <= 1'b1;
    end else if (cycle_count % 3000 < 1500) begin
      vert_stall <= 1'b0;  // stall-free stretch
    end else begin
      vert_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  // Vertex checker at the rising edge.
  always @(posedge clk) begin
    vertex_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && vert_valid && !vert_stall) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d", $time, vertex_x, vertex_y);
        error_count++;
      end else begin
        want = pending_vertices.pop_front();
        if (vertex_x !== want.x) begin
          $display("%0t: vertex_x expected %0d actual %0d", $time, want.x, vertex_x);
          error_count++;
        end
        if (vertex_y !== want.y) begin
          $display("%0t: vertex_y expected %0d actual %0d", $time, want.y, vertex_y);
          error_count++;
        end
        if (vertex_type !== want.vtype) begin
          $display("%0t: vertex_type expected %0d actual %0d", $time, want.vtype,
                   vertex_type);
          error_count++;
        end
        if (word_index !== want.widx) begin
          $display("%0t: word_index expected %0d actual %0d", $time, want.widx,
                   word_index);
          error_count++;
        end
        if (vertex_number !== want.vnum) begin
          $display("%0t: vertex_number expected %0d actual %0d", $time, want.vnum,
                   vertex_number);
          error_count++;
        end
        if (last_vertex !== want.last) begin
          $display("%0t: last_vertex expected %0d actual %0d", $time, want.last,
                   last_vertex);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d vertices outstanding", cycle_count,
               pending_vertices.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Long receiver hold-off while segments keep coming, so the input backs up.
  initial begin
    wait (segments_sent == 40);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    seg_row_t table_rows[$];
    seg_row_t row;
    int idle;
    // directed rows: horizontal/vertical lines give offsets at a glance
    row.has_off = 1;
    row.seg = '{0, 0, 32'h0001_0000, 0, 24'h02_0000, 8'h00, 16'h0000};
    row.ox = 0; row.oy = 64'sh1_0000; table_rows.push_back(row);
    row.seg = '{0, 0, 0, 32'h0001_0000, 24'h02_0000, 8'hFF, 16'h0010};
    row.ox = -64'sh1_0000; row.oy = 0; table_rows.push_back(row);
    row.seg = '{0, 0, -32'sh0001_0000, 0, 24'hFFFFFF, 8'h55, 16'hFFEE};
    row.ox = 0; row.oy = -64'sh80_0000; table_rows.push_back(row);
    row.seg = '{0, 32'h0005_0000, 0, 0, 24'h00_0001, 8'hAA, 16'hFFFF};
    row.ox = 1; row.oy = 0; table_rows.push_back(row);
    // zero length: no offset at all
    row.seg = '{32'h1234_5678, -32'sh1000, 32'h1234_5678, -32'sh1000, 24'hFFFFFF,
                8'h01, 16'h8000};
    row.ox = 0; row.oy = 0; table_rows.push_back(row);
    row.seg = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h00_0000,
                8'h80, 16'h7FFF};
    table_rows.push_back(row);
    // zero thickness
    row.seg = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0000,
                8'h7F, 16'h5555};
    table_rows.push_back(row);
    // extremes, saturation and small deltas: rest goes to the predictor
    row.has_off = 0;
    row.seg = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                24'hFFFFFF, 8'hF0, 16'hAAAA}; table_rows.push_back(row);
    row.seg = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                24'hFFFFFF, 8'h0F, 16'h0001}; table_rows.push_back(row);
    row.seg = '{32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h0000_0001, 24'hFFFFFF,
                8'h33, 16'hFFF0}; table_rows.push_back(row);
    row.seg = '{32'h8000_0000, 0, 32'h8000_0000, -32'sh1, 24'hFFFFFF,
                8'hCC, 16'h1234}; table_rows.push_back(row);
    row.seg = '{0, 0, 3, 4, 24'h0A_0000, 8'h12, 16'h4321}; table_rows.push_back(row);
    row.seg = '{0, 0, -1, 1, 24'h00_0003, 8'h21, 16'h0F0F}; table_rows.push_back(row);
    row.seg = '{100, 200, 32'h4000_0000, -32'sh4000_0000, 24'h7FFFFF, 8'hE1,
                16'hF0F0}; table_rows.push_back(row);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (table_rows[i])
      send_segment(table_rows[i].seg, table_rows[i].has_off, table_rows[i].ox,
                   table_rows[i].oy);
    for (int n = 0; n < NUM_RANDOM; n++) send_segment(rand_segment(), 0, 0, 0);
    stim_done = 1'b1;

    wait (pending_vertices.size() == 0);
    // quiet period; anything arriving now is flagged by the checker
    idle = 0;
    while (idle < 200) begin
      @(posedge clk);
      idle++;
    end

    $display("Sent %0d segments (directed corners, random, zero-length, saturating),",
             segments_sent);
    $display("checked %0d vertices under random stalls and one long back-pressure hold.",
             vertices_seen);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
